### hw/rtl/utf8_to_utf16_decoder_top_macros.svh
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder_top_macros
// Assertion macros shared by the decoder checkers. Clock and reset are aclk
// and aresetn in the scope where the macros are used.
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_UTF16_DECODER_TOP_MACROS_SVH
`define UTF8_TO_UTF16_DECODER_TOP_MACROS_SVH

// checked only while out of reset
`define U2U_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked during reset as well
`define U2U_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

### hw/rtl/u2u_pkg.sv
// ----------------------------------------------------------------------------
// u2u_pkg
// Types and constants for the UTF-8 to UTF-16 decoder.
// ----------------------------------------------------------------------------
package u2u_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [15:0] REPL_UNIT      = 16'hFFFD;
    localparam logic [15:0] NULL_UNIT      = 16'h0000;
    localparam logic [15:0] BOM_UNIT       = 16'hFEFF;
    localparam logic [15:0] HI_SURR_BASE   = 16'hD800;
    localparam logic [5:0]  LO_SURR_PREFIX = 6'b110111;
    localparam logic [20:0] SUPP_OFFSET    = 21'h10000;
    localparam logic [31:0] CNT_MAX        = 32'hFFFF_FFFF;

    // configuration register indexes
    localparam logic REG_INVALID_TO_NULL = 1'b0;
    localparam logic REG_SKIP_BOM        = 1'b1;

    typedef struct packed {
        logic        invalid_to_null;
        logic        skip_bom;
    } u2u_cfg_t;

    // one decoded byte: one unit, or a surrogate pair
    typedef struct packed {
        logic [15:0] unit_first;
        logic [15:0] unit_second;
        logic        pair;
        logic        replaced;
        logic [31:0] invalid_total;
    } u2u_entry_t;

endpackage

### hw/rtl/u2u_front.sv
// ----------------------------------------------------------------------------
// u2u_front
// Byte classifier and sequence accumulator. Emits one queue entry per byte
// that produces output.
// ----------------------------------------------------------------------------
module u2u_front import u2u_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  u2u_cfg_t   cfg,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       q_full,
    output logic       q_push,
    output u2u_entry_t q_entry
);

    logic [1:0]  pending_reg, pending_next;
    logic [20:0] accum_reg, accum_next;
    logic        header_reg, header_next;
    logic [31:0] invalid_reg, invalid_next;

    logic        accept;
    logic        is_cont;
    logic [20:0] shifted;
    logic [20:0] offset_val;
    logic [15:0] hi_unit;
    logic [15:0] lo_unit;

    assign s_ready    = !q_full;
    assign accept     = s_valid && s_ready;
    assign is_cont    = (s_data_byte[7:6] == 2'b10);
    assign shifted    = {accum_reg[14:0], s_data_byte[5:0]};
    assign offset_val = shifted - SUPP_OFFSET;
    assign hi_unit    = HI_SURR_BASE + {5'd0, offset_val[20:10]};
    assign lo_unit    = {LO_SURR_PREFIX, offset_val[9:0]};

    always_comb begin
        pending_next = pending_reg;
        accum_next   = accum_reg;
        header_next  = header_reg;
        invalid_next = invalid_reg;
        q_push       = 1'b0;
        q_entry      = '{unit_first: shifted[15:0], unit_second: lo_unit, pair: 1'b0,
                         replaced: 1'b0, invalid_total: invalid_reg};
        if (accept) begin
            if (pending_reg != 2'd0) begin
                if (is_cont) begin
                    pending_next = pending_reg - 2'd1;
                    accum_next   = shifted;
                    if (pending_reg == 2'd1) begin
                        accum_next = '0;
                        if (shifted[20:16] != 5'd0) begin
                            header_next        = 1'b1;
                            q_push             = 1'b1;
                            q_entry.unit_first = hi_unit;
                            q_entry.pair       = 1'b1;
                        end else if (cfg.skip_bom && !header_reg
                                     && shifted[15:0] == BOM_UNIT) begin
                            header_next = 1'b1;
                        end else begin
                            header_next = 1'b1;
                            q_push      = 1'b1;
                        end
                    end
                end else begin
                    // interrupted sequence: replace, count, drop the byte
                    pending_next = '0;
                    accum_next   = '0;
                    header_next  = 1'b1;
                    if (invalid_reg != CNT_MAX) begin
                        invalid_next = invalid_reg + 32'd1;
                    end
                    q_push                = 1'b1;
                    q_entry.unit_first    = cfg.invalid_to_null ? NULL_UNIT : REPL_UNIT;
                    q_entry.replaced      = 1'b1;
                    q_entry.invalid_total = invalid_next;
                end
            end else if (!s_data_byte[7]) begin
                header_next        = 1'b1;
                q_push             = 1'b1;
                q_entry.unit_first = {8'd0, s_data_byte};
            end else if (s_data_byte[7:5] == 3'b110) begin
                accum_next   = {16'd0, s_data_byte[4:0]};
                pending_next = 2'd1;
            end else if (s_data_byte[7:4] == 4'b1110) begin
                accum_next   = {17'd0, s_data_byte[3:0]};
                pending_next = 2'd2;
            end else if (s_data_byte[7:3] == 5'b11110) begin
                accum_next   = {18'd0, s_data_byte[2:0]};
                pending_next = 2'd3;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
            accum_reg   <= '0;
            header_reg  <= 1'b0;
            invalid_reg <= '0;
        end else begin
            pending_reg <= pending_next;
            accum_reg   <= accum_next;
            header_reg  <= header_next;
            invalid_reg <= invalid_next;
        end
    end

endmodule

### hw/rtl/u2u_queue.sv
// ----------------------------------------------------------------------------
// u2u_queue
// Small entry queue between the classifier and the output sequencer.
// ----------------------------------------------------------------------------
module u2u_queue import u2u_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  u2u_entry_t push_entry,
    output logic       full,
    input  logic       pop,
    output logic       empty,
    output u2u_entry_t pop_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    u2u_entry_t       mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign pop_entry = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### hw/rtl/u2u_back.sv
// ----------------------------------------------------------------------------
// u2u_back
// Output sequencer. Pops queue entries and drives one code unit per word,
// splitting surrogate pairs over two words.
// ----------------------------------------------------------------------------
module u2u_back import u2u_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_empty,
    output logic        q_pop,
    input  u2u_entry_t  q_entry,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_code_unit,
    output logic        m_replaced,
    output logic        m_last_unit,
    output logic [31:0] m_invalid_total
);

    logic        valid_reg, valid_next;
    logic [15:0] unit_reg, unit_next;
    logic        replaced_reg, replaced_next;
    logic        last_reg, last_next;
    logic [31:0] total_reg, total_next;
    logic        lo_pend_reg, lo_pend_next;
    logic [15:0] lo_unit_reg, lo_unit_next;
    logic        slot_free;

    assign slot_free = !valid_reg || m_ready;

    always_comb begin
        valid_next    = valid_reg;
        unit_next     = unit_reg;
        replaced_next = replaced_reg;
        last_next     = last_reg;
        total_next    = total_reg;
        lo_pend_next  = lo_pend_reg;
        lo_unit_next  = lo_unit_reg;
        q_pop         = 1'b0;
        if (slot_free) begin
            if (lo_pend_reg) begin
                valid_next    = 1'b1;
                unit_next     = lo_unit_reg;
                replaced_next = 1'b0;
                last_next     = 1'b1;
                lo_pend_next  = 1'b0;
            end else if (!q_empty) begin
                q_pop         = 1'b1;
                valid_next    = 1'b1;
                unit_next     = q_entry.unit_first;
                replaced_next = q_entry.replaced;
                last_next     = !q_entry.pair;
                total_next    = q_entry.invalid_total;
                lo_pend_next  = q_entry.pair;
                lo_unit_next  = q_entry.unit_second;
            end else begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= 1'b0;
            lo_pend_reg <= 1'b0;
        end else begin
            valid_reg   <= valid_next;
            lo_pend_reg <= lo_pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        unit_reg     <= unit_next;
        replaced_reg <= replaced_next;
        last_reg     <= last_next;
        total_reg    <= total_next;
        lo_unit_reg  <= lo_unit_next;
    end

    assign m_valid         = valid_reg;
    assign m_code_unit     = unit_reg;
    assign m_replaced      = replaced_reg;
    assign m_last_unit     = last_reg;
    assign m_invalid_total = total_reg;

endmodule

### hw/rtl/utf8_to_utf16_decoder_top.sv
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder_top
// UTF-8 byte stream in, UTF-16 code units out, with an APB register port.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while s_ready is high. ASCII and completed
// sequences up to U+FFFF give one word (a leading BOM is dropped while
// skip_bom is set), code points above U+FFFF give a surrogate pair over two
// consecutive words, and a sequence cut by a non-continuation byte gives a
// replacement word; stray continuations and bad leads are dropped. The
// output register issues one unit per cycle while m_ready is high; a
// QUEUE_DEPTH entry queue absorbs output stalls and s_ready drops when full.
// Registers: 0x0 invalid_to_null, 0x4 skip_bom.
// ----------------------------------------------------------------------------
module utf8_to_utf16_decoder_top import u2u_pkg::*; #(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_code_unit,
    output logic        m_replaced,
    output logic        m_last_unit,
    output logic [31:0] m_invalid_total
);

    u2u_cfg_t   cfg_reg, cfg_next;
    logic       reg_wr;
    logic       q_full;
    logic       q_empty;
    logic       q_push;
    logic       q_pop;
    u2u_entry_t push_entry;
    u2u_entry_t pop_entry;

    assign pready = 1'b1;
    assign reg_wr = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (reg_wr) begin
            case (paddr[2])
                REG_INVALID_TO_NULL: cfg_next.invalid_to_null = pwdata[0];
                REG_SKIP_BOM:        cfg_next.skip_bom        = pwdata[0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_INVALID_TO_NULL: prdata = {31'd0, cfg_reg.invalid_to_null};
            REG_SKIP_BOM:        prdata = {31'd0, cfg_reg.skip_bom};
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{invalid_to_null: 1'b0, skip_bom: 1'b1};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    u2u_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_entry     (push_entry)
    );

    u2u_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .empty      (q_empty),
        .pop_entry  (pop_entry)
    );

    u2u_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_empty         (q_empty),
        .q_pop           (q_pop),
        .q_entry         (pop_entry),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_code_unit     (m_code_unit),
        .m_replaced      (m_replaced),
        .m_last_unit     (m_last_unit),
        .m_invalid_total (m_invalid_total)
    );

endmodule

### hw/rtl/u2u_checker.sv
// ----------------------------------------------------------------------------
// u2u_checker
// Port-level checks on the decoder output channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "utf8_to_utf16_decoder_top_macros.svh"

module u2u_checker import u2u_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [15:0] m_code_unit,
    input logic        m_replaced,
    input logic        m_last_unit
);

`U2U_ASSERT_RST(a_reset_idle, !aresetn |=> !m_valid, "output valid after reset")
`U2U_ASSERT(a_stall_hold, m_valid && !m_ready |=> m_valid && $stable(m_code_unit), "word dropped")
`U2U_ASSERT(a_repl_last, m_valid && m_replaced |-> m_last_unit, "replacement not last unit")
`U2U_ASSERT(a_repl_code,
    m_valid && m_replaced |-> m_code_unit == NULL_UNIT || m_code_unit == REPL_UNIT,
    "bad replacement unit")

endmodule

bind utf8_to_utf16_decoder_top u2u_checker u_checker (.*);

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the UTF-8 to UTF-16 decoder. A short table of
// directed bytes (BOM at stream start, range extremes, surrogate pairs,
// stray and invalid bytes, interrupted sequences) is followed by random
// phases of mostly well-formed characters mixed with truncated sequences
// and junk bytes, under every register setting. Each accepted byte goes
// through a local decoder model; every output word is checked in order.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          LIMIT_CYCLES = 200000;
    localparam int          PHASE_BYTES  = 450;
    localparam int          DIR_ROWS     = 26;
    localparam logic [15:0] UNIT_REPL    = 16'hFFFD;
    localparam logic [15:0] UNIT_NULL    = 16'h0000;
    localparam logic [20:0] CP_BOM       = 21'h00FEFF;
    localparam logic [20:0] CP_BMP_MAX   = 21'h00FFFF;
    localparam logic [20:0] CP_SUPP_BASE = 21'h010000;
    localparam logic [15:0] SURR_HI_BASE = 16'hD800;
    localparam logic [5:0]  SURR_LO_TAG  = 6'b110111;

    typedef struct {
        logic [15:0] unit;
        logic        repl;
        logic        last;
        logic [31:0] total;
    } unit_t;

    typedef struct packed {
        logic [7:0]  data;
        logic        typed;
        logic [15:0] unit;
        logic        repl;
        logic [31:0] total;
    } row_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [2:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = '0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [15:0] m_code_unit;
    logic        m_replaced;
    logic        m_last_unit;
    logic [31:0] m_invalid_total;

    // decoder model state
    logic        cfg_to_null  = 1'b0;
    logic        cfg_skip_bom = 1'b1;
    logic [1:0]  seq_left     = '0;
    logic [20:0] cp_acc       = '0;
    logic        started      = 1'b0;
    logic [31:0] bad_seqs     = '0;

    unit_t units_due[$];
    int    mismatches = 0;
    int    cycles     = 0;
    int    sent_bytes = 0;
    bit    steady     = 1'b0;

    row_t dir_rows [DIR_ROWS] = '{
        '{8'hEF, 1'b0, 16'h0000, 1'b0, 32'd0},   // BOM first: dropped
        '{8'hBB, 1'b0, 16'h0000, 1'b0, 32'd0},
        '{8'hBF, 1'b0, 16'h0000, 1'b0, 32'd0},
        '{8'h00, 1'b1, 16'h0000, 1'b0, 32'd0},
        '{8'h7F, 1'b1, 16'h007F, 1'b0, 32'd0},
        '{8'hC2, 1'b0, 16'h0000, 1'b0, 32'd0},   // U+0080
        '{8'h80, 1'b0, 16'h0000, 1'b0, 32'd0},
        '{8'hF0, 1'b0, 16'h0000, 1'b0, 32'd0},   // U+10000, lowest pair
        '{8'h90, 1'b0, 16'h0000, 1'b0, 32'd0},
        '{8'h80, 1'b0, 16'h0000, 1'b0, 32'd0},
        '{8'h80, 1'b0, 16'h0000, 1'b0, 32'd0},
        '{8'hF7, 1'b0, 16'h0000, 1'b0, 32'd0},   // 0x1FFFFF, high unit leaves the high-surrogate range
        '{8'hBF, 1'b0, 16'h0000, 1'b0, 32'd0},
        '{8'hBF, 1'b0, 16'h0000, 1'b0, 32'd0},
        '{8'hBF, 1'b0, 16'h0000, 1'b0, 32'd0},
        '{8'h80, 1'b0, 16'h0000, 1'b0, 32'd0},   // stray continuation
        '{8'hF8, 1'b0, 16'h0000, 1'b0, 32'd0},   // bad leads
        '{8'hFF, 1'b0, 16'h0000, 1'b0, 32'd0},
        '{8'hC3, 1'b0, 16'h0000, 1'b0, 32'd0},   // cut by ASCII
        '{8'h41, 1'b1, UNIT_REPL,  1'b1, 32'd1},
        '{8'hE2, 1'b0, 16'h0000, 1'b0, 32'd0},   // cut by a lead byte
        '{8'h82, 1'b0, 16'h0000, 1'b0, 32'd0},
        '{8'hE2, 1'b1, UNIT_REPL,  1'b1, 32'd2},
        '{8'hEF, 1'b0, 16'h0000, 1'b0, 32'd0},   // BOM later: kept
        '{8'hBB, 1'b0, 16'h0000, 1'b0, 32'd0},
        '{8'hBF, 1'b0, 16'h0000, 1'b0, 32'd0}
    };

    utf8_to_utf16_decoder_top dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_code_unit     (m_code_unit),
        .m_replaced      (m_replaced),
        .m_last_unit     (m_last_unit),
        .m_invalid_total (m_invalid_total)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_ready <= steady || ($urandom_range(99) >= 20);
    end

    function automatic void queue_unit(input logic [15:0] u, input logic r, input logic l);
        unit_t e;
        e.unit  = u;
        e.repl  = r;
        e.last  = l;
        e.total = bad_seqs;
        units_due.push_back(e);
    endfunction

    function automatic void decode_byte(input logic [7:0] b);
        logic [20:0] cp;
        logic [20:0] ofs;
        if (seq_left != 2'd0) begin
            if (b[7:6] == 2'b10) begin
                cp_acc   = {cp_acc[14:0], b[5:0]};
                seq_left = seq_left - 2'd1;
                if (seq_left == 2'd0) begin
                    cp     = cp_acc;
                    cp_acc = '0;
                    if (cp > CP_BMP_MAX) begin
                        ofs     = cp - CP_SUPP_BASE;
                        started = 1'b1;
                        queue_unit(SURR_HI_BASE + {5'd0, ofs[20:10]}, 1'b0, 1'b0);
                        queue_unit({SURR_LO_TAG, ofs[9:0]}, 1'b0, 1'b1);
                        return;
                    end
                    if (cfg_skip_bom && !started && cp == CP_BOM) begin
                        started = 1'b1;
                        return;
                    end
                    started = 1'b1;
                    queue_unit(cp[15:0], 1'b0, 1'b1);
                end
                return;
            end
            // sequence cut short: one replacement word, this byte is lost
            seq_left = '0;
            cp_acc   = '0;
            if (bad_seqs != '1)
                bad_seqs = bad_seqs + 32'd1;
            started = 1'b1;
            queue_unit(cfg_to_null ? UNIT_NULL : UNIT_REPL, 1'b1, 1'b1);
            return;
        end
        if (b[7] == 1'b0) begin
            started = 1'b1;
            queue_unit({8'h00, b}, 1'b0, 1'b1);
        end else if (b[7:5] == 3'b110) begin
            cp_acc   = {16'd0, b[4:0]};
            seq_left = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
            cp_acc   = {17'd0, b[3:0]};
            seq_left = 2'd2;
        end else if (b[7:3] == 5'b11110) begin
            cp_acc   = {18'd0, b[2:0]};
            seq_left = 2'd3;
        end
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic push_byte(input logic [7:0] b, input int row);
        unit_t fixed;
        while (!steady && $urandom_range(99) < 20) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        do @(posedge aclk); while (!s_ready);
        decode_byte(b);
        if (row >= 0 && dir_rows[row].typed) begin
            fixed       = units_due.pop_back();
            fixed.unit  = dir_rows[row].unit;
            fixed.repl  = dir_rows[row].repl;
            fixed.last  = 1'b1;
            fixed.total = dir_rows[row].total;
            units_due.push_back(fixed);
        end
        sent_bytes++;
        @(negedge aclk);
    endtask

    task automatic drain(input int extra);
        s_valid <= 1'b0;
        @(negedge aclk);
        while (units_due.size() != 0)
            @(negedge aclk);
        repeat (extra) @(negedge aclk);
    endtask

    task automatic set_reg(input logic idx, input logic val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {31'($urandom), val};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (idx == u2u_pkg::REG_INVALID_TO_NULL)
            cfg_to_null = val;
        else
            cfg_skip_bom = val;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    // one random character: mostly well formed, some truncated, some junk
    task automatic send_char();
        int          kind;
        int          n;
        int          m;
        int          k;
        logic [20:0] cp;
        logic [7:0]  lead;
        kind = $urandom_range(99);
        cp   = 21'($urandom);
        if (kind < 25) begin
            push_byte(8'($urandom_range(127)), -1);
        end else if (kind < 95) begin
            n = (kind < 45 || kind >= 85) ? 2 + (kind % 3) : (kind < 65 ? 3 : 4);
            case (n)
                2: begin
                    lead = {3'b110, cp[10:6]};
                end
                3: begin
                    lead = {4'b1110, cp[15:12]};
                end
                default: begin
                    lead = {5'b11110, cp[20:18]};
                end
            endcase
            m = (kind >= 85) ? $urandom_range(n - 2) : n - 1;
            push_byte(lead, -1);
            for (k = n - 2; k >= n - 1 - m; k--)
                push_byte({2'b10, 6'(cp >> (6 * k))}, -1);
        end else begin
            push_byte(8'($urandom_range(255, 128)), -1);
        end
    endtask

    always @(posedge aclk) begin : check_units
        unit_t want;
        if (aresetn && m_valid && m_ready) begin
            if (units_due.size() == 0) begin
                $display("%0t: unexpected word unit=%h repl=%b last=%b total=%0d",
                         $realtime, m_code_unit, m_replaced, m_last_unit, m_invalid_total);
                mismatches++;
            end else begin
                want = units_due.pop_front();
                if (m_code_unit !== want.unit || m_replaced !== want.repl ||
                    m_last_unit !== want.last || m_invalid_total !== want.total) begin
                    $display("%0t: expected unit=%h repl=%b last=%b total=%0d", $realtime,
                             want.unit, want.repl, want.last, want.total);
                    $display("%0t:   actual unit=%h repl=%b last=%b total=%0d", $realtime,
                             m_code_unit, m_replaced, m_last_unit, m_invalid_total);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        int   i;
        int   p;
        int   base;
        bit   held;
        logic cfg_null [4];
        logic cfg_bom  [4];
        cfg_null = '{1'b1, 1'b0, 1'b1, 1'b0};
        cfg_bom  = '{1'b0, 1'b1, 1'b1, 1'b0};
        held     = 1'b0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        for (i = 0; i < DIR_ROWS; i++)
            push_byte(dir_rows[i].data, i);
        for (p = 0; p < 4; p++) begin
            drain(8);
            set_reg(u2u_pkg::REG_INVALID_TO_NULL, cfg_null[p]);
            set_reg(u2u_pkg::REG_SKIP_BOM, cfg_bom[p]);
            steady = (p == 2);
            base   = sent_bytes;
            while (sent_bytes - base < PHASE_BYTES) begin
                if (p == 1 && !held && sent_bytes - base >= 200) begin
                    drain(0);
                    held = 1'b1;
                end
                if (p == 2 && sent_bytes - base >= 300)
                    steady = 1'b0;
                send_char();
            end
        end
        drain(20);
        if (mismatches == 0 && units_due.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
